[hdl/tlpte_pkg.sv]
`default_nettype none
package tlpte_pkg;

   localparam int DIR_BITS_DEFAULT = 4;
   localparam int VA_WIDTH         = 26;
   localparam int FRAME_WIDTH      = 20;
   localparam int TI_WIDTH         = 10;
   localparam int VA_DIR_WIDTH     = 4;
   localparam int ENTRY_WIDTH      = 24;
   localparam int FLAG_WIDTH       = 6;
   localparam int QUEUE_DEPTH      = 2;

   typedef enum logic [1:0] {
      OP_TRANSLATE = 2'd0,
      OP_MAP       = 2'd1,
      OP_REMAP     = 2'd2,
      OP_UNMAP     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FAULT  = 2'd1,
      ST_DENIED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LOOKUP,
      BK_CLEAR,
      BK_FINISH
   } back_state_type;

   typedef struct packed {
      logic [1:0]             command;
      logic [VA_WIDTH-1:0]    virt_addr;
      logic [FRAME_WIDTH-1:0] phys_frame;
      logic                   want_read;
      logic                   want_write;
      logic                   no_cache;
      logic                   user_access;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [FLAG_WIDTH-1:0]  fault_flags;
      logic [FRAME_WIDTH-1:0] frame_out;
      logic                   flush_needed;
      logic                   table_created;
   } rsp_type;

   // decoded command as it waits in the queue
   typedef struct packed {
      op_type                  op;
      logic                    deny;
      logic [VA_DIR_WIDTH-1:0] dir_field;
      logic [TI_WIDTH-1:0]     ti;
      logic [FRAME_WIDTH-1:0]  frame;
      logic                    wr;
      logic                    nc;
      logic                    us;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type item;
   } queue_out_type;

endpackage
`default_nettype wire

[hdl/tlpte_front.sv]
`default_nettype none
module tlpte_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire tlpte_pkg::req_type     req_item,
   input  wire logic                   pop,
   output tlpte_pkg::queue_out_type    q_out
);
   localparam int PtrW = $clog2(tlpte_pkg::QUEUE_DEPTH);
   localparam int CntW = $clog2(tlpte_pkg::QUEUE_DEPTH + 1);

   tlpte_pkg::cmd_type slot_ff [tlpte_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   tlpte_pkg::cmd_type decoded;
   logic push;

   // classify: commands without read right are refused up front, except unmap
   always_comb begin
      decoded.op        = tlpte_pkg::op_type'(req_item.command);
      decoded.deny      = !req_item.want_read &&
                          (req_item.command != tlpte_pkg::OP_UNMAP);
      decoded.dir_field = req_item.virt_addr[22 +: tlpte_pkg::VA_DIR_WIDTH];
      decoded.ti        = req_item.virt_addr[12 +: tlpte_pkg::TI_WIDTH];
      decoded.frame     = req_item.phys_frame;
      decoded.wr        = req_item.want_write;
      decoded.nc        = req_item.no_cache;
      decoded.us        = req_item.user_access;
   end

   assign busy = (count_ff == CntW'(tlpte_pkg::QUEUE_DEPTH));
   assign push = start && !busy;
   assign q_out.valid = (count_ff != '0);
   assign q_out.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PtrW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = (pop && q_out.valid) ? PtrW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push) - CntW'(pop && q_out.valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end
endmodule
`default_nettype wire

[hdl/tlpte_back.sv]
`default_nettype none
module tlpte_back #(
   parameter int DIR_BITS = tlpte_pkg::DIR_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire tlpte_pkg::queue_out_type q_out,
   output logic                          pop,
   output logic                          rsp_valid,
   output tlpte_pkg::rsp_type            rsp_item
);
   localparam int AddrW = DIR_BITS + tlpte_pkg::TI_WIDTH;
   localparam int TiW   = tlpte_pkg::TI_WIDTH;
   localparam int FrW   = tlpte_pkg::FRAME_WIDTH;

   logic [tlpte_pkg::ENTRY_WIDTH-1:0] mem [2**AddrW];
   logic [tlpte_pkg::ENTRY_WIDTH-1:0] rd_data_ff;
   logic [2:0] dir_ff [2**DIR_BITS];

   tlpte_pkg::back_state_type state_ff, state_in;
   tlpte_pkg::cmd_type item_ff, item_in;
   logic [TiW-1:0] clr_ff, clr_in;

   logic [AddrW-1:0] rd_addr, wr_addr;
   logic [tlpte_pkg::ENTRY_WIDTH-1:0] wr_data, te, new_entry;
   logic wr_en, dir_we, create;
   logic [DIR_BITS-1:0] di, q_di;
   logic [2:0] de;
   logic [tlpte_pkg::FLAG_WIDTH-1:0] ff_dir, ff_all;
   logic [3:0] newflags;

   assign di    = DIR_BITS'(item_ff.dir_field);
   assign q_di  = DIR_BITS'(q_out.item.dir_field);
   assign rd_addr = {q_di, q_out.item.ti};
   assign te    = rd_data_ff;
   assign de    = dir_ff[di];
   assign newflags = {item_ff.nc, item_ff.us, item_ff.wr, 1'b1};
   assign new_entry = {item_ff.frame, newflags};
   assign create = (state_ff == tlpte_pkg::BK_LOOKUP) && !item_ff.deny &&
                   (item_ff.op == tlpte_pkg::OP_MAP) && !de[0];

   // translate walk flags; table level only when the directory is clean
   always_comb begin
      ff_dir = {3'b000, !de[2] && item_ff.us, !de[1] && item_ff.wr, !de[0]};
      ff_all = ff_dir;
      if (ff_dir == '0) begin
         ff_all = {!te[2] && item_ff.us, !te[1] && item_ff.wr, !te[0], 3'b000};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tlpte_pkg::BK_IDLE:   if (q_out.valid) state_in = tlpte_pkg::BK_LOOKUP;
         tlpte_pkg::BK_LOOKUP: state_in = create ? tlpte_pkg::BK_CLEAR : tlpte_pkg::BK_IDLE;
         tlpte_pkg::BK_CLEAR:  if (clr_ff == '1) state_in = tlpte_pkg::BK_FINISH;
         tlpte_pkg::BK_FINISH: state_in = tlpte_pkg::BK_IDLE;
         default:              state_in = tlpte_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop       = 1'b0;
      item_in   = item_ff;
      clr_in    = '0;
      wr_en     = 1'b0;
      wr_addr   = {di, item_ff.ti};
      wr_data   = new_entry;
      dir_we    = 1'b0;
      rsp_valid = 1'b0;
      rsp_item  = '0;
      case (state_ff)
         tlpte_pkg::BK_IDLE: begin
            pop     = q_out.valid;
            item_in = q_out.item;
         end
         tlpte_pkg::BK_LOOKUP: begin
            rsp_valid = !create;
            if (item_ff.deny) begin
               rsp_item.status = tlpte_pkg::ST_DENIED;
            end else begin
               case (item_ff.op)
                  tlpte_pkg::OP_TRANSLATE: begin
                     rsp_item.fault_flags = ff_all;
                     if (ff_all == '0) begin
                        rsp_item.frame_out = te[4 +: FrW];
                     end else if (ff_all[0] || ff_all[3]) begin
                        rsp_item.status = tlpte_pkg::ST_FAULT;
                     end else begin
                        rsp_item.status = tlpte_pkg::ST_DENIED;
                     end
                  end
                  tlpte_pkg::OP_MAP: begin
                     if (create) begin
                        dir_we = 1'b1;
                     end else begin
                        wr_en = 1'b1;
                        rsp_item.flush_needed = te[0] &&
                           ((te[1] && !item_ff.wr) || (te[2] && !item_ff.us) ||
                            (te[4 +: FrW] != item_ff.frame));
                     end
                  end
                  tlpte_pkg::OP_REMAP: begin
                     if (!de[0] || !te[0]) begin
                        rsp_item.status = tlpte_pkg::ST_FAULT;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = {te[4 +: FrW], newflags};
                        rsp_item.flush_needed = (te[1] && !item_ff.wr) ||
                                                (te[2] && !item_ff.us);
                     end
                  end
                  tlpte_pkg::OP_UNMAP: begin
                     if (!de[0] || !te[0]) begin
                        rsp_item.status = tlpte_pkg::ST_FAULT;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = '0;
                        rsp_item.flush_needed = 1'b1;
                     end
                  end
                  default: rsp_item.status = tlpte_pkg::ST_FAULT;
               endcase
            end
         end
         tlpte_pkg::BK_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = {di, clr_ff};
            wr_data = '0;
            clr_in  = TiW'(clr_ff + 1'b1);
         end
         tlpte_pkg::BK_FINISH: begin
            wr_en     = 1'b1;
            rsp_valid = 1'b1;
            rsp_item.table_created = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlpte_pkg::BK_IDLE;
         clr_ff   <= '0;
         for (int i = 0; i < 2**DIR_BITS; i++) dir_ff[i] <= 3'b000;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (dir_we) dir_ff[di] <= 3'b111;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[hdl/two_level_page_table_engine_core.sv]
// Two-level page table engine. Commands (translate, map, remap, unmap) enter
// on start while busy is low and land in a two-beat queue; the back end walks
// the register-held directory and the table memory (one read port, one write
// port). The back end handles each command as a registered table read, then
// an evaluate and write-back step, and pops the next one only when idle. A map
// that finds its directory entry missing creates the table and clears all
// 1024 entries one per cycle, then writes the new entry. Every command gives
// exactly one result beat, shown for one cycle with rsp_valid; the receiver
// cannot stall, so take each beat when it comes.
// Table contents are undefined after reset; only tables created by map are
// ever walked, and the directory resets to not present.
`default_nettype none
module two_level_page_table_engine_core #(
   parameter int DIR_BITS = tlpte_pkg::DIR_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire tlpte_pkg::req_type req_item,
   output logic                    rsp_valid,
   output tlpte_pkg::rsp_type      rsp_item
);
   tlpte_pkg::queue_out_type q_out;
   logic pop;

   // accept and classify, then hold in the queue
   tlpte_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .pop      (pop),
      .q_out    (q_out)
   );

   // walk, update and answer
   tlpte_back #(.DIR_BITS(DIR_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_out     (q_out),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );
endmodule
`default_nettype wire

[hdl/tlpte_checker.sv]
`default_nettype none
module tlpte_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire tlpte_pkg::rsp_type rsp_item
);
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result beats too close");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.status == tlpte_pkg::ST_OK ||
                     rsp_item.status == tlpte_pkg::ST_FAULT ||
                     rsp_item.status == tlpte_pkg::ST_DENIED))
      else $error("bad status");

   a_ok_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == tlpte_pkg::ST_OK) |-> rsp_item.fault_flags == '0)
      else $error("fault flags on ok");

   a_frame_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.frame_out != '0) |-> rsp_item.status == tlpte_pkg::ST_OK)
      else $error("frame on failure");

   a_created_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.table_created) |->
      (rsp_item.status == tlpte_pkg::ST_OK && !rsp_item.flush_needed))
      else $error("bad create result");
endmodule

bind two_level_page_table_engine_core tlpte_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
`default_nettype wire

[tb/two_level_page_table_engine_core_tb.sv]
`default_nettype none
module two_level_page_table_engine_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIR_COUNT = 1 << tlpte_pkg::DIR_BITS_DEFAULT;
   localparam int TABLE_SIZE = 1024;
   localparam int RANDOM_ITEMS = 1750;
   // bound: every item creating a table plus sender gaps, with margin
   localparam longint CYCLE_LIMIT = 64'd8_000_000;

   // entry flag bits in the shadow table
   localparam logic [3:0] PTE_PRESENT = 4'h1;
   localparam logic [3:0] PTE_WRITE   = 4'h2;
   localparam logic [3:0] PTE_USER    = 4'h4;
   localparam logic [3:0] PTE_NOCACHE = 4'h8;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   tlpte_pkg::req_type req_item;
   logic               rsp_valid;
   tlpte_pkg::rsp_type rsp_item;

   two_level_page_table_engine_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   // shadow copy of the page directory and page tables
   logic [2:0]  shadow_dir [DIR_COUNT];
   logic [23:0] shadow_pte [DIR_COUNT*TABLE_SIZE];

   tlpte_pkg::req_type pending_cmds[$];
   tlpte_pkg::rsp_type expected_rsps[$];
   int      mismatch_count = 0;
   int      beats_checked = 0;
   int      tables_made = 0;
   longint  cycle_count = 0;
   bit      driver_gaps = 1;
   bit      gap_enable = 1;
   logic    busy_at_edge = 1'b1;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // compute the result of one command and update the shadow tables
   function automatic tlpte_pkg::rsp_type walk_and_update(tlpte_pkg::req_type r);
      tlpte_pkg::rsp_type res;
      int          di;
      int          slot;
      logic [2:0]  de;
      logic [23:0] te;
      logic [5:0]  ff;
      logic [3:0]  nflags;
      di = int'(r.virt_addr[25:22]);
      slot = di * TABLE_SIZE + int'(r.virt_addr[21:12]);
      de = shadow_dir[di];
      te = shadow_pte[slot];
      nflags = (r.want_write ? PTE_WRITE : 4'h0) | (r.no_cache ? PTE_NOCACHE : 4'h0)
               | (r.user_access ? PTE_USER : 4'h0);
      res = '0;
      case (tlpte_pkg::op_type'(r.command))
         tlpte_pkg::OP_TRANSLATE: begin
            ff = '0;
            if (!r.want_read) begin
               res.status = tlpte_pkg::ST_DENIED;
            end else begin
               if (!de[0]) ff[0] = 1'b1;
               if (!de[1] && r.want_write) ff[1] = 1'b1;
               if (!de[2] && r.user_access) ff[2] = 1'b1;
               if (ff == 0) begin
                  if (!te[0]) ff[3] = 1'b1;
                  if (!te[1] && r.want_write) ff[4] = 1'b1;
                  if (!te[2] && r.user_access) ff[5] = 1'b1;
               end
               if (ff != 0) begin
                  res.status = (ff[0] || ff[3]) ? tlpte_pkg::ST_FAULT : tlpte_pkg::ST_DENIED;
                  res.fault_flags = ff;
               end else begin
                  res.status = tlpte_pkg::ST_OK;
                  res.frame_out = te[23:4];
               end
            end
         end
         tlpte_pkg::OP_MAP: begin
            if (!r.want_read) begin
               res.status = tlpte_pkg::ST_DENIED;
            end else begin
               if (!de[0]) begin
                  shadow_dir[di] = 3'b111;
                  for (int i = 0; i < TABLE_SIZE; i++) shadow_pte[di*TABLE_SIZE+i] = '0;
                  res.table_created = 1'b1;
                  tables_made++;
                  te = '0;
               end
               if (te[0] && ((te[1] && !r.want_write) || (te[2] && !r.user_access)
                             || te[23:4] != r.phys_frame))
                  res.flush_needed = 1'b1;
               shadow_pte[slot] = {r.phys_frame, PTE_PRESENT | nflags};
               res.status = tlpte_pkg::ST_OK;
            end
         end
         tlpte_pkg::OP_REMAP: begin
            if (!r.want_read) begin
               res.status = tlpte_pkg::ST_DENIED;
            end else if (!de[0] || !te[0]) begin
               res.status = tlpte_pkg::ST_FAULT;
            end else begin
               if ((te[1] && !r.want_write) || (te[2] && !r.user_access))
                  res.flush_needed = 1'b1;
               shadow_pte[slot] = {te[23:4], PTE_PRESENT | nflags};
               res.status = tlpte_pkg::ST_OK;
            end
         end
         default: begin
            if (!de[0] || !te[0]) begin
               res.status = tlpte_pkg::ST_FAULT;
            end else begin
               shadow_pte[slot] = '0;
               res.status = tlpte_pkg::ST_OK;
               res.flush_needed = 1'b1;
            end
         end
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // build one command beat with random low address bits, frame and write, user and no-cache bits
   function automatic tlpte_pkg::req_type make_cmd(int cmd, int di, int ti, bit reads);
      tlpte_pkg::req_type r;
      r.command = 2'(cmd);
      r.virt_addr = {4'(di), 10'(ti), 12'($urandom_range(0, 4095))};
      r.phys_frame = 20'($urandom);
      r.want_read = reads;
      r.want_write = 1'($urandom);
      r.no_cache = 1'($urandom);
      r.user_access = 1'($urandom);
      return r;
   endfunction

   // driver: offer the next beat at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy_at_edge) begin
         // previous beat taken at this rising edge
         if (pending_cmds.size() > 0 && !(gap_enable && $urandom_range(0, 99) < 32)) begin
            req_item <= pending_cmds.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (pending_cmds.size() > 0 && driver_gaps
             && !(gap_enable && $urandom_range(0, 99) < 32)) begin
            req_item <= pending_cmds.pop_front();
            start <= 1'b1;
         end
      end
   end

   // sample the accept condition and predict at the rising edge
   always @(posedge clock) begin
      cycle_count++;
      busy_at_edge <= busy;
      if (!reset && start && !busy) expected_rsps.push_back(walk_and_update(req_item));
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_item, 0);
         end else begin
            tlpte_pkg::rsp_type want;
            want = expected_rsps.pop_front();
            beats_checked++;
            if (rsp_item.status !== want.status)
               report_mismatch("status", rsp_item.status, want.status);
            if (rsp_item.fault_flags !== want.fault_flags)
               report_mismatch("fault_flags", rsp_item.fault_flags, want.fault_flags);
            if (rsp_item.frame_out !== want.frame_out)
               report_mismatch("frame_out", rsp_item.frame_out, want.frame_out);
            if (rsp_item.flush_needed !== want.flush_needed)
               report_mismatch("flush_needed", rsp_item.flush_needed, want.flush_needed);
            if (rsp_item.table_created !== want.table_created)
               report_mismatch("table_created", rsp_item.table_created, want.table_created);
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("two_level_page_table_engine_core_tb failed");
         $finish;
      end
   end

   function automatic tlpte_pkg::req_type pick_random();
      int cmd;
      int di;
      int roll;
      roll = $urandom_range(0, 99);
      cmd = $urandom_range(0, 3);
      di = $urandom_range(0, DIR_COUNT - 1);
      // lean on a few directories so mappings get reused
      if (roll < 70) di = $urandom_range(0, 3);
      // every command but map stops at the directory check when its directory is missing
      return make_cmd(cmd, di, (roll < 85) ? $urandom_range(0, 7) : $urandom_range(0, 1023),
                      $urandom_range(0, 9) != 0);
   endfunction

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || expected_rsps.size() > 0 || start)
         @(posedge clock);
      repeat (1100) @(posedge clock);
   endtask

   initial begin
      tlpte_pkg::req_type r;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      for (int i = 0; i < DIR_COUNT; i++) shadow_dir[i] = '0;
      for (int i = 0; i < DIR_COUNT*TABLE_SIZE; i++) shadow_pte[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed: missing directory, denial, create, extremes of fields
      pending_cmds.push_back(make_cmd(tlpte_pkg::OP_TRANSLATE, 0, 0, 1));
      pending_cmds.push_back(make_cmd(tlpte_pkg::OP_TRANSLATE, 15, 1023, 0));
      pending_cmds.push_back(make_cmd(tlpte_pkg::OP_REMAP, 0, 0, 1));
      pending_cmds.push_back(make_cmd(tlpte_pkg::OP_UNMAP, 15, 1023, 0));
      pending_cmds.push_back(make_cmd(tlpte_pkg::OP_MAP, 0, 0, 0));
      r = make_cmd(tlpte_pkg::OP_MAP, 0, 0, 1);
      r.phys_frame = '0; r.virt_addr = '0;
      pending_cmds.push_back(r);
      r = make_cmd(tlpte_pkg::OP_MAP, 15, 1023, 1);
      r.phys_frame = '1; r.virt_addr = '1; r.want_write = 1; r.user_access = 1;
      pending_cmds.push_back(r);
      r.command = tlpte_pkg::OP_TRANSLATE; pending_cmds.push_back(r);
      r.want_read = 0; pending_cmds.push_back(r);
      r.want_read = 1; r.command = tlpte_pkg::OP_MAP; r.want_write = 0; r.user_access = 0;
      pending_cmds.push_back(r);                      // drop rights: flush
      r.command = tlpte_pkg::OP_TRANSLATE; r.want_write = 1; r.user_access = 1;
      pending_cmds.push_back(r);                      // table-level faults
      r.command = tlpte_pkg::OP_REMAP; pending_cmds.push_back(r);
      r.want_write = 0; pending_cmds.push_back(r);    // remap drops write
      r.command = tlpte_pkg::OP_MAP; r.phys_frame = 20'h12345; pending_cmds.push_back(r);
      r.command = tlpte_pkg::OP_UNMAP; r.want_read = 0; pending_cmds.push_back(r);
      r.command = tlpte_pkg::OP_UNMAP; pending_cmds.push_back(r); // now missing
      r.command = tlpte_pkg::OP_TRANSLATE; r.want_read = 1; pending_cmds.push_back(r);
      r.command = tlpte_pkg::OP_REMAP; pending_cmds.push_back(r);
      wait_drained();

      // random, with a stretch of back-to-back beats and a full drain pause
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pending_cmds.push_back(pick_random());
         if (n == 600) begin
            gap_enable = 0;
         end else if (n == 900) begin
            while (pending_cmds.size() > 0) @(posedge clock);
            gap_enable = 1;
         end else if (n == 1200) begin
            wait_drained();
         end
         if (pending_cmds.size() > 8) @(posedge clock);
      end
      wait_drained();

      $display("checked %0d result beats over all four commands, %0d tables created",
               beats_checked, tables_made);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("two_level_page_table_engine_core_tb passed");
      end else begin
         $display("two_level_page_table_engine_core_tb failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
hdl/tlpte_pkg.sv
hdl/tlpte_front.sv
hdl/tlpte_back.sv
hdl/two_level_page_table_engine_core.sv
hdl/tlpte_checker.sv
tb/two_level_page_table_engine_core_tb.sv
